/* src/cdt_pkg.sv */
// ============================================================================
// cdt_pkg
// Shared constants, register indexes, mode codes and the structs that pass
// between the countdown timer's sequencer, divider and top level.
// ============================================================================
package cdt_pkg;

  localparam int TICKS_PER_SECOND = 1000;
  localparam int ELAPSED_BITS     = 24;

  localparam int FADE_Q      = 8;
  localparam int NUM_W       = ELAPSED_BITS + FADE_Q;
  localparam int CNT_W       = $clog2(ELAPSED_BITS + 1);
  localparam int SEC_PER_MIN = 60;
  localparam int MINUTE_TICKS = SEC_PER_MIN * TICKS_PER_SECOND;
  localparam int MT_W        = $clog2(MINUTE_TICKS + 1);
  localparam int PROD_W      = MT_W + 8;
  localparam int DUR_W       = PROD_W + ELAPSED_BITS;
  localparam int REM_SEC_W   = 6;
  localparam int CFG_DATA_W  = 24;
  localparam int CFG_IDX_W   = 3;

  localparam logic [ELAPSED_BITS-1:0] TICK_MAX = '1;
  localparam logic [7:0] LED_MAX = 8'hFF;

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_RUN  = 2'd1;
  localparam logic [1:0] MODE_DONE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MIN   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_COLOR = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_COLOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_PER  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DONE_COLOR = 3'd5;

  typedef struct packed {
    logic [7:0]  left_minutes;
    logic [23:0] left_color;
    logic [7:0]  right_minutes;
    logic [23:0] right_color;
    logic [15:0] flash_period;
    logic [23:0] done_color;
  } cfg_t;

  typedef struct packed {
    logic                    start;
    logic                    long_div;
    logic [NUM_W-1:0]        num;
    logic [ELAPSED_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic [ELAPSED_BITS-1:0] quo;
    logic [ELAPSED_BITS-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [7:0]           led_red;
    logic [7:0]           led_green;
    logic [7:0]           led_blue;
    logic [1:0]           mode;
    logic [7:0]           rem_min;
    logic [REM_SEC_W-1:0] rem_sec;
    logic                 buzzer;
    logic                 backlight;
  } result_t;

endpackage

/* src/cdt_div.sv */
// ============================================================================
// cdt_div
// Bit-serial restoring divider: one quotient bit per cycle. Short mode
// yields a FADE_Q-bit quotient from a NUM_W-bit numerator whose quotient is
// known to fit; long mode divides an ELAPSED_BITS-bit numerator in full.
// ============================================================================
module cdt_div (
  input  logic              clk,
  input  logic              rst_n,
  input  cdt_pkg::div_req_t req,
  output cdt_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [cdt_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [cdt_pkg::ELAPSED_BITS-1:0]  rem_r, rem_nxt;
  logic [cdt_pkg::NUM_W-1:0]         sh_r, sh_nxt;
  logic [cdt_pkg::ELAPSED_BITS-1:0]  den_r, den_nxt;

  logic [cdt_pkg::ELAPSED_BITS:0]    trial;
  logic [cdt_pkg::ELAPSED_BITS:0]    diff;
  logic                              ge;

  assign trial = {rem_r, sh_r[cdt_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    sh_nxt   = sh_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      den_nxt  = req.den;
      if (req.long_div) begin
        rem_nxt = '0;
        sh_nxt  = {req.num[cdt_pkg::ELAPSED_BITS-1:0], {cdt_pkg::FADE_Q{1'b0}}};
        cnt_nxt = cdt_pkg::CNT_W'(cdt_pkg::ELAPSED_BITS);
      end else begin
        rem_nxt = req.num[cdt_pkg::NUM_W-1:cdt_pkg::FADE_Q];
        sh_nxt  = {req.num[cdt_pkg::FADE_Q-1:0], {cdt_pkg::ELAPSED_BITS{1'b0}}};
        cnt_nxt = cdt_pkg::CNT_W'(cdt_pkg::FADE_Q);
      end
    end else if (busy_r) begin
      rem_nxt = ge ? diff[cdt_pkg::ELAPSED_BITS-1:0] : trial[cdt_pkg::ELAPSED_BITS-1:0];
      sh_nxt  = {sh_r[cdt_pkg::NUM_W-2:0], ge};
      cnt_nxt = cnt_r - cdt_pkg::CNT_W'(1);
      if (cnt_r == cdt_pkg::CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    sh_r  <= sh_nxt;
    den_r <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = sh_r[cdt_pkg::ELAPSED_BITS-1:0];
  assign rsp.rem  = rem_r;

endmodule

/* src/cdt_seq.sv */
// ============================================================================
// cdt_seq
// Tick sequencer: button edge detection, timer mode, flash phase, and the
// division schedule for the three fade channels and the remaining time.
// ============================================================================
module cdt_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  cdt_pkg::cfg_t     cfg,
  input  logic              in_take,
  input  logic              left_button,
  input  logic              mid_button,
  input  logic              right_button,
  output cdt_pkg::div_req_t div_req,
  input  cdt_pkg::div_rsp_t div_rsp,
  input  logic              slot_free,
  output logic              busy,
  output logic              res_load,
  output cdt_pkg::result_t  res
);

  localparam logic [1:0] ST_WAIT = 2'd0;
  localparam logic [1:0] ST_EVAL = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  localparam logic [2:0] STEP_RED  = 3'd0;
  localparam logic [2:0] STEP_GRN  = 3'd1;
  localparam logic [2:0] STEP_BLU  = 3'd2;
  localparam logic [2:0] STEP_SEC  = 3'd3;
  localparam logic [2:0] STEP_MIN  = 3'd4;

  localparam int EB = cdt_pkg::ELAPSED_BITS;

  logic [1:0]          state_r, state_nxt;
  logic [1:0]          mode_r, mode_nxt;
  logic                lprev_r, mprev_r, rprev_r;
  logic [EB-1:0]       elapsed_r, elapsed_nxt;
  logic [EB-1:0]       dur_r, dur_nxt;
  logic [23:0]         target_r, target_nxt;
  logic [15:0]         fcnt_r, fcnt_nxt;
  logic                fon_r, fon_nxt;
  logic [2:0]          step_r, step_nxt;
  logic [7:0]          red_r, red_nxt;
  logic [7:0]          grn_r, grn_nxt;
  logic [7:0]          blu_r, blu_nxt;
  logic [7:0]          rmin_r, rmin_nxt;
  logic [cdt_pkg::REM_SEC_W-1:0] rsec_r, rsec_nxt;

  logic                le, me, re;
  logic [15:0]         fcnt_inc;
  logic [7:0]          sel_min;
  logic [cdt_pkg::PROD_W-1:0] prod;
  logic [cdt_pkg::DUR_W-1:0]  prod_x;
  logic [EB-1:0]       dur_sat;
  logic [2:0]          issue_step;
  logic [7:0]          tgt_byte;
  logic [7:0]          span;
  logic [7:0]          fade_val;

  assign le = left_button  & ~lprev_r;
  assign me = mid_button   & ~mprev_r;
  assign re = right_button & ~rprev_r;

  assign fcnt_inc = fcnt_r + 16'd1;
  assign sel_min  = le ? cfg.left_minutes : cfg.right_minutes;
  assign prod     = cdt_pkg::PROD_W'(sel_min) *
                    cdt_pkg::PROD_W'(cdt_pkg::MINUTE_TICKS);
  assign prod_x   = cdt_pkg::DUR_W'(prod);
  assign dur_sat  = (prod_x > cdt_pkg::DUR_W'(cdt_pkg::TICK_MAX)) ?
                    cdt_pkg::TICK_MAX : prod_x[EB-1:0];

  assign issue_step = (state_r == ST_EVAL) ? STEP_RED : (step_r + 3'd1);
  assign fade_val   = cdt_pkg::LED_MAX - div_rsp.quo[7:0];

  always_comb begin
    case (issue_step)
      STEP_RED: tgt_byte = target_r[23:16];
      STEP_GRN: tgt_byte = target_r[15:8];
      default:  tgt_byte = target_r[7:0];
    endcase
  end
  assign span = cdt_pkg::LED_MAX - tgt_byte;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.long_div = 1'b0;
    div_req.num      = cdt_pkg::NUM_W'(span) * cdt_pkg::NUM_W'(elapsed_r);
    div_req.den      = dur_r;
    if (state_r == ST_EVAL) begin
      div_req.start = (elapsed_r < dur_r);
    end else if (state_r == ST_DIV) begin
      div_req.start = div_rsp.done && (step_r != STEP_MIN);
    end
    case (issue_step)
      STEP_SEC: begin
        div_req.long_div = 1'b1;
        div_req.num      = cdt_pkg::NUM_W'(dur_r - elapsed_r);
        div_req.den      = EB'(cdt_pkg::TICKS_PER_SECOND);
      end
      STEP_MIN: begin
        div_req.long_div = 1'b1;
        div_req.num      = cdt_pkg::NUM_W'(div_rsp.quo);
        div_req.den      = EB'(cdt_pkg::SEC_PER_MIN);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    mode_nxt    = mode_r;
    elapsed_nxt = elapsed_r;
    dur_nxt     = dur_r;
    target_nxt  = target_r;
    fcnt_nxt    = fcnt_r;
    fon_nxt     = fon_r;
    step_nxt    = step_r;
    red_nxt     = red_r;
    grn_nxt     = grn_r;
    blu_nxt     = blu_r;
    rmin_nxt    = rmin_r;
    rsec_nxt    = rsec_r;
    res_load    = 1'b0;
    case (state_r)
      ST_WAIT: begin
        if (in_take) begin
          state_nxt = ST_OUT;
          case (mode_r)
            cdt_pkg::MODE_RUN: begin
              if (me) begin
                mode_nxt = cdt_pkg::MODE_IDLE;
              end else begin
                if (elapsed_r < cdt_pkg::TICK_MAX) begin
                  elapsed_nxt = elapsed_r + EB'(1);
                end
                state_nxt = ST_EVAL;
              end
            end
            cdt_pkg::MODE_DONE: begin
              if (le || me || re) begin
                mode_nxt = cdt_pkg::MODE_IDLE;
              end else if (fcnt_inc >= cfg.flash_period) begin
                fcnt_nxt = '0;
                fon_nxt  = ~fon_r;
              end else begin
                fcnt_nxt = fcnt_inc;
              end
            end
            default: begin
              mode_nxt = cdt_pkg::MODE_IDLE;
              if (le || re) begin
                mode_nxt    = cdt_pkg::MODE_RUN;
                dur_nxt     = dur_sat;
                elapsed_nxt = '0;
                target_nxt  = le ? cfg.left_color : cfg.right_color;
                state_nxt   = ST_EVAL;
              end
            end
          endcase
        end
      end
      ST_EVAL: begin
        if (elapsed_r >= dur_r) begin
          mode_nxt  = cdt_pkg::MODE_DONE;
          fcnt_nxt  = '0;
          fon_nxt   = 1'b0;
          state_nxt = ST_OUT;
        end else begin
          step_nxt  = STEP_RED;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          step_nxt = step_r + 3'd1;
          case (step_r)
            STEP_RED: red_nxt = fade_val;
            STEP_GRN: grn_nxt = fade_val;
            STEP_BLU: blu_nxt = fade_val;
            STEP_MIN: begin
              rmin_nxt  = (div_rsp.quo > EB'(cdt_pkg::LED_MAX)) ?
                          cdt_pkg::LED_MAX : div_rsp.quo[7:0];
              rsec_nxt  = div_rsp.rem[cdt_pkg::REM_SEC_W-1:0];
              state_nxt = ST_OUT;
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        if (slot_free) begin
          res_load  = 1'b1;
          state_nxt = ST_WAIT;
        end
      end
    endcase
  end

  always_comb begin
    res.led_red   = '0;
    res.led_green = '0;
    res.led_blue  = '0;
    res.mode      = mode_r;
    res.rem_min   = '0;
    res.rem_sec   = '0;
    res.buzzer    = 1'b0;
    res.backlight = 1'b1;
    case (mode_r)
      cdt_pkg::MODE_RUN: begin
        res.led_red   = red_r;
        res.led_green = grn_r;
        res.led_blue  = blu_r;
        res.rem_min   = rmin_r;
        res.rem_sec   = rsec_r;
      end
      cdt_pkg::MODE_DONE: begin
        if (fon_r) begin
          res.led_red   = cfg.done_color[23:16];
          res.led_green = cfg.done_color[15:8];
          res.led_blue  = cfg.done_color[7:0];
          res.buzzer    = 1'b1;
        end else begin
          res.backlight = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign busy = (state_r != ST_WAIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_WAIT;
      mode_r    <= cdt_pkg::MODE_IDLE;
      lprev_r   <= 1'b0;
      mprev_r   <= 1'b0;
      rprev_r   <= 1'b0;
      elapsed_r <= '0;
      dur_r     <= '0;
      target_r  <= '0;
      fcnt_r    <= '0;
      fon_r     <= 1'b0;
      step_r    <= STEP_RED;
    end else begin
      state_r   <= state_nxt;
      mode_r    <= mode_nxt;
      if (in_take) begin
        lprev_r <= left_button;
        mprev_r <= mid_button;
        rprev_r <= right_button;
      end
      elapsed_r <= elapsed_nxt;
      dur_r     <= dur_nxt;
      target_r  <= target_nxt;
      fcnt_r    <= fcnt_nxt;
      fon_r     <= fon_nxt;
      step_r    <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r  <= red_nxt;
    grn_r  <= grn_nxt;
    blu_r  <= blu_nxt;
    rmin_r <= rmin_nxt;
    rsec_r <= rsec_nxt;
  end

endmodule

/* src/countdown_timer_color_fade.sv */
// ============================================================================
// countdown_timer_color_fade
// Countdown timer with RGB fade toward a preset color and a flashing
// expiry indication, one transaction per millisecond tick.
// ============================================================================
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | left, mid, right button levels
//  out_    | output    | out_valid/out_stall| LEDs, mode, remaining, buzzer, backlight
//  cfg_    | input     | cfg_we             | cfg_index, cfg_data (24 bits)
//
// A running tick passes from the wait state through evaluation and the bit-serial
// divider (three fade quotients, then seconds, then minutes) to the output state,
// and the input stalls until it is back in wait. Idle, cancel and flashing ticks
// go straight from wait to output; a tick that expires the timer passes through
// evaluation first. Reset is synchronous; configuration returns to its preset values.
// The result sits in an output register; the next transaction is taken while
// it waits, and the sequencer holds its finished result until the register frees.
module countdown_timer_color_fade (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_left_button,
  input  logic                             in_mid_button,
  input  logic                             in_right_button,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [7:0]                       out_led_red,
  output logic [7:0]                       out_led_green,
  output logic [7:0]                       out_led_blue,
  output logic [1:0]                       out_mode_out,
  output logic [7:0]                       out_remaining_min,
  output logic [cdt_pkg::REM_SEC_W-1:0]    out_remaining_sec,
  output logic                             out_buzzer_on,
  output logic                             out_backlight_on,
  input  logic                             cfg_we,
  input  logic [cdt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cdt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  cdt_pkg::cfg_t     cfg_r;
  cdt_pkg::div_req_t div_req;
  cdt_pkg::div_rsp_t div_rsp;
  cdt_pkg::result_t  res;
  cdt_pkg::result_t  out_r;
  logic              out_valid_r;
  logic              seq_busy;
  logic              res_load;
  logic              slot_free;
  logic              in_take;

  assign in_stall  = seq_busy | ~rst_n;
  assign in_take   = in_valid & ~in_stall;
  assign slot_free = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.left_minutes  <= 8'd20;
      cfg_r.left_color    <= 24'hFF0000;
      cfg_r.right_minutes <= 8'd30;
      cfg_r.right_color   <= 24'h0000FF;
      cfg_r.flash_period  <= 16'd400;
      cfg_r.done_color    <= 24'h00FF00;
    end else if (cfg_we) begin
      case (cfg_index)
        cdt_pkg::CFG_LEFT_MIN:    cfg_r.left_minutes  <= cfg_data[7:0];
        cdt_pkg::CFG_LEFT_COLOR:  cfg_r.left_color    <= cfg_data;
        cdt_pkg::CFG_RIGHT_MIN:   cfg_r.right_minutes <= cfg_data[7:0];
        cdt_pkg::CFG_RIGHT_COLOR: cfg_r.right_color   <= cfg_data;
        cdt_pkg::CFG_FLASH_PER:   cfg_r.flash_period  <= cfg_data[15:0];
        cdt_pkg::CFG_DONE_COLOR:  cfg_r.done_color    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cdt_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_take      (in_take),
    .left_button  (in_left_button),
    .mid_button   (in_mid_button),
    .right_button (in_right_button),
    .div_req      (div_req),
    .div_rsp      (div_rsp),
    .slot_free    (slot_free),
    .busy         (seq_busy),
    .res_load     (res_load),
    .res          (res)
  );

  cdt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_led_red       = out_r.led_red;
  assign out_led_green     = out_r.led_green;
  assign out_led_blue      = out_r.led_blue;
  assign out_mode_out      = out_r.mode;
  assign out_remaining_min = out_r.rem_min;
  assign out_remaining_sec = out_r.rem_sec;
  assign out_buzzer_on     = out_r.buzzer;
  assign out_backlight_on  = out_r.backlight;

endmodule

/* src/cdt_chk.sv */
// ============================================================================
// cdt_chk
// Port-level checker for the countdown timer, bound to the top level.
// ============================================================================
module cdt_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [7:0]                     out_led_red,
  input logic [7:0]                     out_led_green,
  input logic [7:0]                     out_led_blue,
  input logic [1:0]                     out_mode_out,
  input logic [7:0]                     out_remaining_min,
  input logic [cdt_pkg::REM_SEC_W-1:0]  out_remaining_sec,
  input logic                           out_buzzer_on,
  input logic                           out_backlight_on
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  a_stalled_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_led_red) &&
      $stable(out_mode_out) && $stable(out_remaining_min))
    else $error("stalled transaction changed");

  a_one_tick_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while a tick is in progress");

  a_no_time_unless_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_out != cdt_pkg::MODE_RUN |->
      out_remaining_min == 8'd0 && out_remaining_sec == '0)
    else $error("remaining time shown outside running mode");

  a_idle_outputs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mode_out == cdt_pkg::MODE_IDLE |->
      out_backlight_on && !out_buzzer_on && out_led_red == 8'd0 &&
      out_led_green == 8'd0 && out_led_blue == 8'd0)
    else $error("idle transaction with LEDs or buzzer driven");

endmodule

bind countdown_timer_color_fade cdt_chk u_cdt_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_led_red       (out_led_red),
  .out_led_green     (out_led_green),
  .out_led_blue      (out_led_blue),
  .out_mode_out      (out_mode_out),
  .out_remaining_min (out_remaining_min),
  .out_remaining_sec (out_remaining_sec),
  .out_buzzer_on     (out_buzzer_on),
  .out_backlight_on  (out_backlight_on)
);

/* bench/tb_countdown_timer_color_fade.sv */
// ============================================================================
// tb_countdown_timer_color_fade
// Drives button ticks into the countdown timer under random source and sink
// idling, predicts every display transaction with an internal timer model,
// and compares each received transaction field by field. Preset registers are
// reloaded between phases, covering zero and full-length timers, extreme
// colors and flash periods.
// ============================================================================
module tb_countdown_timer_color_fade;

  localparam int CLK_HALF         = 6;
  localparam int RESET_CYCLES     = 8;
  localparam int WATCHDOG_LIMIT   = 4000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int CFG_SETTLE       = 8;
  localparam int END_SETTLE       = 200;
  localparam int MAX_REPORTS      = 10;
  localparam int BTN_LEFT         = 0;
  localparam int BTN_MID          = 1;
  localparam int BTN_RIGHT        = 2;

  localparam logic [cdt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [cdt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_stall;
  logic                           in_left_button;
  logic                           in_mid_button;
  logic                           in_right_button;
  logic                           out_valid;
  logic                           out_stall;
  logic [7:0]                     out_led_red;
  logic [7:0]                     out_led_green;
  logic [7:0]                     out_led_blue;
  logic [1:0]                     out_mode_out;
  logic [7:0]                     out_remaining_min;
  logic [cdt_pkg::REM_SEC_W-1:0]  out_remaining_sec;
  logic                           out_buzzer_on;
  logic                           out_backlight_on;
  logic                           cfg_we;
  logic [cdt_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [cdt_pkg::CFG_DATA_W-1:0] cfg_data;

  bit         long_hold_req = 1'b0;
  bit         quiet_tail    = 1'b0;
  logic [2:0] btn_lv        = '0;

  class timer_display_model;
    logic [7:0]                       left_min;
    logic [23:0]                      left_rgb;
    logic [7:0]                       right_min;
    logic [23:0]                      right_rgb;
    logic [15:0]                      flash_per;
    logic [23:0]                      done_rgb;
    logic [1:0]                       mode;
    logic                             left_q;
    logic                             mid_q;
    logic                             right_q;
    logic [cdt_pkg::ELAPSED_BITS-1:0] elapsed;
    logic [cdt_pkg::ELAPSED_BITS-1:0] duration;
    logic [23:0]                      target;
    logic [15:0]                      flash_cnt;
    logic                             flash_phase;
    cdt_pkg::result_t                 shown;
    cdt_pkg::result_t                 pending_displays[$];
    int                               mismatches;

    function new();
      left_min    = 8'd20;
      left_rgb    = 24'hFF0000;
      right_min   = 8'd30;
      right_rgb   = 24'h0000FF;
      flash_per   = 16'd400;
      done_rgb    = 24'h00FF00;
      mode        = cdt_pkg::MODE_IDLE;
      left_q      = 1'b0;
      mid_q       = 1'b0;
      right_q     = 1'b0;
      elapsed     = '0;
      duration    = '0;
      target      = '0;
      flash_cnt   = '0;
      flash_phase = 1'b0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [cdt_pkg::CFG_IDX_W-1:0] idx,
                          logic [cdt_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cdt_pkg::CFG_LEFT_MIN:    left_min  = data[7:0];
        cdt_pkg::CFG_LEFT_COLOR:  left_rgb  = data[23:0];
        cdt_pkg::CFG_RIGHT_MIN:   right_min = data[7:0];
        cdt_pkg::CFG_RIGHT_COLOR: right_rgb = data[23:0];
        cdt_pkg::CFG_FLASH_PER:   flash_per = data[15:0];
        cdt_pkg::CFG_DONE_COLOR:  done_rgb  = data[23:0];
        default: ;
      endcase
    endfunction

    function void start_timer(logic [7:0] minutes, logic [23:0] rgb);
      int unsigned ticks;
      ticks = minutes * cdt_pkg::MINUTE_TICKS;
      duration = (ticks > cdt_pkg::TICK_MAX) ? cdt_pkg::TICK_MAX :
                 cdt_pkg::ELAPSED_BITS'(ticks);
      elapsed = '0;
      target = rgb;
      mode = cdt_pkg::MODE_RUN;
    endfunction

    function logic [7:0] faded(logic [7:0] goal);
      longint unsigned span;
      longint unsigned drop;
      span = 64'(cdt_pkg::LED_MAX) - 64'(goal);
      drop = (span * 64'(elapsed)) / 64'(duration);
      return 8'(64'(cdt_pkg::LED_MAX) - drop);
    endfunction

    function void eval_running();
      logic [cdt_pkg::ELAPSED_BITS-1:0] left_ticks;
      int unsigned secs;
      int unsigned mins;
      if (elapsed >= duration) begin
        mode = cdt_pkg::MODE_DONE;
        flash_cnt = '0;
        flash_phase = 1'b0;
        return;
      end
      shown.led_red = faded(target[23:16]);
      shown.led_green = faded(target[15:8]);
      shown.led_blue = faded(target[7:0]);
      left_ticks = duration - elapsed;
      secs = left_ticks / cdt_pkg::TICKS_PER_SECOND;
      mins = secs / cdt_pkg::SEC_PER_MIN;
      shown.rem_min = (mins > 255) ? 8'd255 : 8'(mins);
      shown.rem_sec = cdt_pkg::REM_SEC_W'(secs % cdt_pkg::SEC_PER_MIN);
    endfunction

    function void take_tick(logic l, logic m, logic r);
      logic le;
      logic me;
      logic re;
      le = l && !left_q;
      me = m && !mid_q;
      re = r && !right_q;
      left_q = l;
      mid_q = m;
      right_q = r;
      shown = '0;
      shown.backlight = 1'b1;
      case (mode)
        cdt_pkg::MODE_RUN: begin
          if (me) begin
            mode = cdt_pkg::MODE_IDLE;
          end else begin
            if (elapsed != cdt_pkg::TICK_MAX) elapsed = elapsed + 1'b1;
            eval_running();
          end
        end
        cdt_pkg::MODE_DONE: begin
          if (le || me || re) begin
            mode = cdt_pkg::MODE_IDLE;
          end else begin
            flash_cnt = flash_cnt + 1'b1;
            if (flash_cnt >= flash_per) begin
              flash_cnt = '0;
              flash_phase = !flash_phase;
            end
          end
        end
        default: begin
          mode = cdt_pkg::MODE_IDLE;
          if (le) start_timer(left_min, left_rgb);
          else if (re) start_timer(right_min, right_rgb);
          if (mode == cdt_pkg::MODE_RUN) eval_running();
        end
      endcase
      if (mode == cdt_pkg::MODE_DONE) begin
        if (flash_phase) begin
          shown.led_red = done_rgb[23:16];
          shown.led_green = done_rgb[15:8];
          shown.led_blue = done_rgb[7:0];
          shown.buzzer = 1'b1;
          shown.backlight = 1'b1;
        end else begin
          shown.backlight = 1'b0;
        end
      end
      shown.mode = mode;
      pending_displays.push_back(shown);
    endfunction

    function string describe(cdt_pkg::result_t d);
      return $sformatf("rgb=%02h%02h%02h mode=%0d rem=%0d:%0d buzzer=%0b backlight=%0b",
                       d.led_red, d.led_green, d.led_blue, d.mode, d.rem_min, d.rem_sec,
                       d.buzzer, d.backlight);
    endfunction

    function void check_display(cdt_pkg::result_t got);
      cdt_pkg::result_t want;
      if (pending_displays.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("unexpected display %s", describe(got));
        return;
      end
      want = pending_displays.pop_front();
      if (got.led_red !== want.led_red || got.led_green !== want.led_green ||
          got.led_blue !== want.led_blue || got.mode !== want.mode ||
          got.rem_min !== want.rem_min || got.rem_sec !== want.rem_sec ||
          got.buzzer !== want.buzzer || got.backlight !== want.backlight) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("display mismatch: expected %s, got %s", describe(want), describe(got));
      end
    endfunction

    function int outstanding();
      return pending_displays.size();
    endfunction

    function bit clean();
      return mismatches == 0 && pending_displays.size() == 0;
    endfunction
  endclass

  timer_display_model display_model;

  countdown_timer_color_fade dut (.*);

  initial clk = 1'b0;
  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      display_model.take_tick(in_left_button, in_mid_button, in_right_button);
  end

  always @(posedge clk) begin : display_monitor
    cdt_pkg::result_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.led_red = out_led_red;
      seen.led_green = out_led_green;
      seen.led_blue = out_led_blue;
      seen.mode = out_mode_out;
      seen.rem_min = out_remaining_min;
      seen.rem_sec = out_remaining_sec;
      seen.buzzer = out_buzzer_on;
      seen.backlight = out_backlight_on;
      display_model.check_display(seen);
    end
  end

  initial begin : sink_pacing
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
      end else if (quiet_tail || $urandom_range(0, 2) != 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 48)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("simulation failed");
    $finish;
  end

  task automatic send_tick(input logic l, input logic m, input logic r);
    in_valid <= 1'b1;
    in_left_button <= l;
    in_mid_button <= m;
    in_right_button <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic pause_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the source until every display has come back, then let the block settle
  task automatic drain(input int settle);
    in_valid <= 1'b0;
    @(posedge clk);
    while (display_model.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [cdt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cdt_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    display_model.set_reg(idx, data);
  endtask

  task automatic load_presets(input logic [23:0] lm, input logic [23:0] lc,
                              input logic [23:0] rm, input logic [23:0] rc,
                              input logic [23:0] fp, input logic [23:0] dc);
    drain(CFG_SETTLE);
    write_reg(cdt_pkg::CFG_LEFT_MIN, lm);
    write_reg(cdt_pkg::CFG_LEFT_COLOR, lc);
    write_reg(cdt_pkg::CFG_RIGHT_MIN, rm);
    write_reg(cdt_pkg::CFG_RIGHT_COLOR, rc);
    write_reg(cdt_pkg::CFG_FLASH_PER, fp);
    write_reg(cdt_pkg::CFG_DONE_COLOR, dc);
    write_reg(CFG_SPARE_LO, 24'($urandom));
    write_reg(CFG_SPARE_HI, 24'($urandom));
    cfg_we <= 1'b0;
  endtask

  // mostly press and release sequences, now and then random levels
  function automatic void step_buttons();
    if ($urandom_range(0, 9) == 0) begin
      btn_lv = 3'($urandom);
    end else begin
      for (int i = 0; i < 3; i++) begin
        if (btn_lv[i]) btn_lv[i] = 1'($urandom_range(0, 1));
        else btn_lv[i] = ($urandom_range(0, (i == BTN_MID) ? 19 : 7) == 0);
      end
    end
  endfunction

  task automatic random_ticks(input int count);
    repeat (count) begin
      step_buttons();
      send_tick(btn_lv[BTN_LEFT], btn_lv[BTN_MID], btn_lv[BTN_RIGHT]);
      if (!quiet_tail && $urandom_range(0, 5) == 0) pause_sender($urandom_range(1, 16));
    end
  endtask

  initial begin : stimulus
    display_model = new();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_left_button <= 1'b0;
    in_mid_button <= 1'b0;
    in_right_button <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // power-on presets: start, ignore edges while running, cancel, priority
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b1, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);

    // zero-length left timer, full-length right timer, zero flash period
    load_presets({16'($urandom), 8'd0}, 24'h000000, 24'd255, 24'hFFFFFF,
                 {8'($urandom), 16'd0}, 24'hFFFFFF);
    send_tick(1'b1, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b1, 1'b0);
    send_tick(1'b1, 1'b0, 1'b1);
    send_tick(1'b0, 1'b0, 1'b0);
    send_tick(1'b0, 1'b0, 1'b1);
    random_ticks(60);

    load_presets(24'd1, 24'($urandom), 24'd0, 24'($urandom), 24'd1, 24'h000000);
    random_ticks(130);

    load_presets(24'd255, 24'hFFFFFF, 24'd0, 24'h000000, 24'hFFFF, 24'($urandom));
    random_ticks(120);

    load_presets(24'($urandom_range(0, 2)), 24'($urandom), 24'($urandom_range(0, 2)),
                 24'($urandom), 24'($urandom_range(2, 6)), 24'($urandom));
    random_ticks(100);
    long_hold_req = 1'b1;
    random_ticks(30);
    drain(0);
    random_ticks(110);
    quiet_tail = 1'b1;
    random_ticks(80);

    drain(END_SETTLE);
    if (display_model.clean()) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
